FILE: src/tds_pkg.sv
// Shared types and constants for the text duration summer.
package tds_pkg;

  localparam int unsigned FifoDepthDef = 4;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned FieldW = 7;
  localparam int unsigned LenW   = 4;
  localparam int unsigned PhaseW = 4;
  localparam int unsigned TimeW  = 19;  // 99*3600 + 99*60 + 99 fits
  localparam int unsigned TotalW = 32;

  localparam logic [LenW-1:0] TimeWordLen = LenW'(8);
  localparam logic [LenW-1:0] LenSat      = LenW'(9);

  localparam logic [11:0] SecPerHour = 12'd3600;
  localparam logic [5:0]  SecPerMin  = 6'd60;

  localparam logic [ByteW-1:0] ChComma = 8'h2C;
  localparam logic [ByteW-1:0] ChDot   = 8'h2E;
  localparam logic [ByteW-1:0] ChDash  = 8'h2D;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChNul   = 8'h00;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;

  // Position in the H-M-S pattern
  localparam logic [PhaseW-1:0] PhH0   = 4'd0;
  localparam logic [PhaseW-1:0] PhH1   = 4'd1;
  localparam logic [PhaseW-1:0] PhH2   = 4'd2;
  localparam logic [PhaseW-1:0] PhM0   = 4'd3;
  localparam logic [PhaseW-1:0] PhM1   = 4'd4;
  localparam logic [PhaseW-1:0] PhM2   = 4'd5;
  localparam logic [PhaseW-1:0] PhS0   = 4'd6;
  localparam logic [PhaseW-1:0] PhS1   = 4'd7;
  localparam logic [PhaseW-1:0] PhDone = 4'd8;

  // One closed word (or end marker) handed from front to back
  typedef struct packed {
    logic              count;
    logic              last;
    logic [FieldW-1:0] hour;
    logic [FieldW-1:0] minute;
    logic [FieldW-1:0] second;
  } tds_word_t;

endpackage

FILE: src/tds_if.sv
// Valid/ready channel interfaces for the byte input and the total output.
interface tds_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface tds_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] total_seconds;

  modport source (output valid, output total_seconds, input ready);
  modport sink (input valid, input total_seconds, output ready);
endinterface

FILE: src/tds_front.sv
// Front end: splits bytes into words and tracks the H-M-S pattern.
module tds_front import tds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  tds_in_if.sink      in_i,
  output logic        push_o,
  output tds_word_t   word_o,
  input  logic        push_ready_i
);

  function automatic logic [FieldW-1:0] dec_step(input logic [FieldW-1:0] v,
                                                 input logic [3:0] d);
    logic [10:0] x;
    x = 11'({4'b0, v}) * 11'd10 + 11'({7'b0, d});
    return x[FieldW-1:0];
  endfunction

  logic [LenW-1:0]   len_q, len_d;
  logic [PhaseW-1:0] ph_q, ph_d;
  logic              good_q, good_d;
  logic [FieldW-1:0] h_q, h_d, m_q, m_d, s_q, s_d;

  logic              accept;
  logic              sep, digit, dash;
  logic [3:0]        dval;
  logic              cur_ok, nxt_ok;
  logic [ByteW-1:0]  b;

  assign b      = in_i.text_byte;
  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = push_ready_i;

  assign sep   = (b >= ChTab && b <= ChCr) || b == ChSpace || b == ChComma ||
                 b == ChDot || b == ChNul;
  assign digit = (b >= ChZero) && (b <= ChNine);
  assign dash  = (b == ChDash);
  assign dval  = 4'(b - ChZero);

  // Pattern advance for one word byte
  always_comb begin
    len_d  = len_q;
    ph_d   = ph_q;
    good_d = good_q;
    h_d    = h_q;
    m_d    = m_q;
    s_d    = s_q;
    if (len_q < LenSat) begin
      len_d = len_q + LenW'(1);
    end
    if (good_q && ph_q < PhDone) begin
      case (ph_q)
        PhH0: begin
          if (digit) begin
            h_d  = FieldW'(dval);
            ph_d = PhH1;
          end else begin
            good_d = 1'b0;
          end
        end
        PhH1: begin
          if (digit) begin
            h_d  = dec_step(h_q, dval);
            ph_d = PhH2;
          end else if (dash) begin
            ph_d = PhM0;
          end else begin
            good_d = 1'b0;
          end
        end
        PhH2: begin
          if (dash) ph_d = PhM0;
          else      good_d = 1'b0;
        end
        PhM0: begin
          if (digit) begin
            m_d  = FieldW'(dval);
            ph_d = PhM1;
          end else begin
            good_d = 1'b0;
          end
        end
        PhM1: begin
          if (digit) begin
            m_d  = dec_step(m_q, dval);
            ph_d = PhM2;
          end else if (dash) begin
            ph_d = PhS0;
          end else begin
            good_d = 1'b0;
          end
        end
        PhM2: begin
          if (dash) ph_d = PhS0;
          else      good_d = 1'b0;
        end
        PhS0: begin
          if (digit) begin
            s_d  = FieldW'(dval);
            ph_d = PhS1;
          end else begin
            good_d = 1'b0;
          end
        end
        PhS1: begin
          if (digit) s_d = dec_step(s_q, dval);
          ph_d = PhDone;
        end
        default: begin
        end
      endcase
    end
  end

  assign cur_ok = (len_q == TimeWordLen) && good_q && (ph_q >= PhS1);
  assign nxt_ok = (len_d == TimeWordLen) && good_d && (ph_d >= PhS1);

  // A separator closes the word as is; a final word byte closes it after update
  always_comb begin
    word_o.last   = in_i.end_of_text;
    word_o.count  = sep ? cur_ok : (in_i.end_of_text && nxt_ok);
    word_o.hour   = sep ? h_q : h_d;
    word_o.minute = sep ? m_q : m_d;
    word_o.second = sep ? s_q : s_d;
  end

  assign push_o = accept && (word_o.count || in_i.end_of_text);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      ph_q   <= PhH0;
      good_q <= 1'b1;
      h_q    <= '0;
      m_q    <= '0;
      s_q    <= '0;
    end else if (accept) begin
      if (sep || in_i.end_of_text) begin
        len_q  <= '0;
        ph_q   <= PhH0;
        good_q <= 1'b1;
        h_q    <= '0;
        m_q    <= '0;
        s_q    <= '0;
      end else begin
        len_q  <= len_d;
        ph_q   <= ph_d;
        good_q <= good_d;
        h_q    <= h_d;
        m_q    <= m_d;
        s_q    <= s_d;
      end
    end
  end

endmodule

FILE: src/tds_fifo.sv
// Small register queue of closed words between front and back.
module tds_fifo import tds_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  tds_word_t push_data_i,
  output logic      push_ready_o,
  output logic      pop_valid_o,
  output tds_word_t pop_data_o,
  input  logic      pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  tds_word_t       mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntFull);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
      if (do_pop)  rd_q <= (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

FILE: src/tds_back.sv
// Back end: converts words to seconds, accumulates and emits the total.
module tds_back import tds_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      word_valid_i,
  input  tds_word_t word_i,
  output logic      pop_o,
  tds_out_if.source out_o
);

  logic              s1_valid_q;
  logic              s1_last_q;
  logic [TimeW-1:0]  s1_time_q;
  logic [TimeW-1:0]  time_d;
  logic [TotalW-1:0] acc_q, sum;
  logic              out_valid_q;
  logic [TotalW-1:0] out_total_q;
  logic              s1_adv;

  // Constant-coefficient products, registered before the accumulate
  assign time_d = word_i.count ?
                  (TimeW'(word_i.hour) * TimeW'(SecPerHour) +
                   TimeW'(word_i.minute) * TimeW'(SecPerMin) +
                   TimeW'(word_i.second)) : '0;

  assign s1_adv = s1_valid_q && (!s1_last_q || !out_valid_q || out_o.ready);
  assign pop_o  = word_valid_i && (!s1_valid_q || s1_adv);
  assign sum    = acc_q + TotalW'(s1_time_q);

  assign out_o.valid         = out_valid_q;
  assign out_o.total_seconds = out_total_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_time_q <= time_d;
      s1_last_q <= word_i.last;
    end
    if (s1_adv && s1_last_q) out_total_q <= sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o)       s1_valid_q <= 1'b1;
      else if (s1_adv) s1_valid_q <= 1'b0;
      if (s1_adv) acc_q <= s1_last_q ? '0 : sum;
      if (s1_adv && s1_last_q) out_valid_q <= 1'b1;
      else if (out_o.ready)    out_valid_q <= 1'b0;
    end
  end

endmodule

FILE: src/text_duration_summer.sv
// Top level of the text duration summer.
//
// in_i carries one text byte per transaction plus end_of_text on the final
// byte. Words are split on whitespace, comma, period and NUL; an 8-byte word
// starting with H-M-S (one or two digits each) adds H*3600+M*60+S to a
// wrapping 32-bit total. On the final byte the total goes out as one
// transaction on out_o and is cleared.
// Throughput: one byte per cycle while the queue has room. The front end
// parses each byte in the cycle it is accepted and queues only closed time
// words and end markers. With nothing queued ahead, the final byte's end
// marker is queued on the accepting edge, then passes the seconds conversion
// register, then the accumulator/output register that drives out_o.
// Reset clears the word state, the queue, the total and the output.
// When out_o stalls, the back end holds at the next end marker, the queue
// fills and in_i.ready drops once it is full; input keeps flowing until then.
module text_duration_summer import tds_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tds_in_if.sink     in_i,
  tds_out_if.source  out_o
);

  logic      push, push_ready, pop, pop_valid;
  tds_word_t push_word, pop_word;

  tds_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_o       (push),
    .word_o       (push_word),
    .push_ready_i (push_ready)
  );

  tds_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_word),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_word),
    .pop_i        (pop)
  );

  tds_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (pop_valid),
    .word_i       (pop_word),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

FILE: tb/sv/text_duration_summer_test.sv
// Self-checking testbench for text_duration_summer: random texts, random pacing, scoreboard.
`timescale 1ns / 100ps

module text_duration_summer_test import tds_pkg::*;;

  localparam int unsigned RandomItems = 1750;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned MaxWait     = 18;
  localparam int unsigned DrainLimit  = 4000;
  localparam int unsigned SettleCycles = 12;
  localparam logic [ByteW-1:0] ChPlus = 8'h2B;

  typedef enum logic [1:0] {
    PaceFull,
    PaceRandom,
    PaceSparse
  } pace_e;

  typedef struct packed {
    logic [ByteW-1:0] value;
    logic             last;
  } text_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tds_in_if  in_ch ();
  tds_out_if out_ch ();

  text_duration_summer dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  text_item_t        byte_feed[$];
  logic [TotalW-1:0] expected_totals[$];
  int unsigned       error_count = 0;
  int unsigned       cycle_count = 0;

  // Predicted word state and total
  logic [LenW-1:0]   word_len = '0;
  logic [PhaseW-1:0] phase = PhH0;
  logic              fmt_ok = 1'b1;
  logic [FieldW-1:0] hr = '0;
  logic [FieldW-1:0] mn = '0;
  logic [FieldW-1:0] sc = '0;
  logic [TotalW-1:0] run_total = '0;

  task automatic report_mismatch(string what);
    error_count++;
    $display("ERROR cycle %0d: %s", cycle_count, what);
  endtask

  function automatic logic is_delim(logic [ByteW-1:0] b);
    return (b >= ChTab && b <= ChCr) || b == ChSpace || b == ChComma ||
           b == ChDot || b == ChNul;
  endfunction

  task automatic settle_word();
    if (word_len == TimeWordLen && fmt_ok && phase >= PhS1) begin
      run_total = run_total + TotalW'(hr) * TotalW'(SecPerHour) +
                  TotalW'(mn) * TotalW'(SecPerMin) + TotalW'(sc);
    end
    word_len = '0;
    phase    = PhH0;
    fmt_ok   = 1'b1;
    hr       = '0;
    mn       = '0;
    sc       = '0;
  endtask

  task automatic step_pattern(logic [ByteW-1:0] b);
    logic              is_dig;
    logic              is_dash;
    logic [FieldW-1:0] d;
    is_dig  = (b >= ChZero) && (b <= ChNine);
    is_dash = (b == ChDash);
    d       = FieldW'(b - ChZero);
    if (fmt_ok) begin
      case (phase)
        PhH0: if (is_dig) begin
          hr    = d;
          phase = PhH1;
        end else fmt_ok = 1'b0;
        PhH1: if (is_dig) begin
          hr    = FieldW'(hr * 10 + d);
          phase = PhH2;
        end else if (is_dash) phase = PhM0;
        else fmt_ok = 1'b0;
        PhH2: if (is_dash) phase = PhM0;
        else fmt_ok = 1'b0;
        PhM0: if (is_dig) begin
          mn    = d;
          phase = PhM1;
        end else fmt_ok = 1'b0;
        PhM1: if (is_dig) begin
          mn    = FieldW'(mn * 10 + d);
          phase = PhM2;
        end else if (is_dash) phase = PhS0;
        else fmt_ok = 1'b0;
        PhM2: if (is_dash) phase = PhS0;
        else fmt_ok = 1'b0;
        PhS0: if (is_dig) begin
          sc    = d;
          phase = PhS1;
        end else fmt_ok = 1'b0;
        PhS1: begin
          if (is_dig) sc = FieldW'(sc * 10 + d);
          phase = PhDone;
        end
        default: ;
      endcase
    end
  endtask

  task automatic absorb_byte(logic [ByteW-1:0] b, logic last);
    if (is_delim(b)) begin
      settle_word();
    end else begin
      if (word_len < LenSat) word_len++;
      step_pattern(b);
    end
    if (last) begin
      settle_word();
      expected_totals.push_back(run_total);
      run_total = '0;
    end
  endtask

  // ---------------- stimulus generation ----------------

  task automatic queue_byte(logic [ByteW-1:0] b, logic last);
    text_item_t it;
    it.value = b;
    it.last  = last;
    byte_feed.push_back(it);
  endtask

  task automatic queue_str(string s, logic last_on_end);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], last_on_end && i == s.len() - 1);
  endtask

  function automatic logic [ByteW-1:0] rand_sep();
    case ($urandom_range(0, 8))
      0:       return ChNul;
      1:       return ChSpace;
      2:       return ChComma;
      3:       return ChDot;
      default: return ByteW'($urandom_range(ChTab, ChCr));
    endcase
  endfunction

  function automatic logic [ByteW-1:0] rand_word_byte();
    logic [ByteW-1:0] b;
    b = ByteW'($urandom_range(0, 255));
    while (is_delim(b)) b = ByteW'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [ByteW-1:0] rand_digit();
    return ChZero + ByteW'($urandom_range(0, 9));
  endfunction

  task automatic put_field(ref logic [ByteW-1:0] w[$], input int unsigned n);
    repeat (n) w.push_back(rand_digit());
  endtask

  task automatic build_word(ref logic [ByteW-1:0] w[$]);
    int unsigned kind;
    int unsigned pos;
    w.delete();
    kind = $urandom_range(0, 9);
    if (kind <= 7) begin
      put_field(w, $urandom_range(1, 2));
      w.push_back(ChDash);
      put_field(w, $urandom_range(1, 2));
      w.push_back(ChDash);
      put_field(w, $urandom_range(1, 2));
      while (w.size() < TimeWordLen) begin
        w.push_back(($urandom_range(0, 2) == 0) ? rand_digit() : rand_word_byte());
      end
      // near misses: wrong length, a corrupted byte or a sign
      if (kind >= 6) begin
        pos = $urandom_range(0, w.size() - 1);
        case ($urandom_range(0, 3))
          0:       void'(w.pop_back());
          1:       repeat ($urandom_range(1, 4)) w.push_back(rand_word_byte());
          2:       w[pos] = rand_word_byte();
          default: w[pos] = ($urandom_range(0, 1) != 0) ? ChPlus : ChDash;
        endcase
      end
    end else if (kind == 8) begin
      repeat ($urandom_range(1, 12)) w.push_back(rand_word_byte());
    end else begin
      repeat ($urandom_range(5, 10)) begin
        case ($urandom_range(0, 11))
          10:      w.push_back(ChDash);
          11:      w.push_back(ChPlus);
          default: w.push_back(rand_digit());
        endcase
      end
    end
  endtask

  task automatic gen_text();
    int unsigned      n_words;
    logic             end_on_sep;
    logic [ByteW-1:0] w[$];
    logic [ByteW-1:0] text_buf[$];
    n_words    = $urandom_range(0, 6);
    end_on_sep = ($urandom_range(0, 1) != 0);
    if ($urandom_range(0, 3) == 0) text_buf.push_back(rand_sep());
    for (int k = 0; k < n_words; k++) begin
      build_word(w);
      foreach (w[j]) text_buf.push_back(w[j]);
      if (k != n_words - 1 || end_on_sep) begin
        repeat ($urandom_range(1, 3)) text_buf.push_back(rand_sep());
      end
    end
    if (text_buf.size() == 0) text_buf.push_back(rand_sep());
    foreach (text_buf[j]) queue_byte(text_buf[j], j == text_buf.size() - 1);
  endtask

  function automatic int unsigned draw_wait(pace_e pace);
    case (pace)
      PaceFull:   return 0;
      PaceRandom: return $urandom_range(0, MaxWait);
      default:    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MaxWait) : 0;
    endcase
  endfunction

  // ---------------- monitor and scoreboard ----------------

  logic        in_acc = 1'b0;
  logic        out_acc = 1'b0;
  logic        out_seen = 1'b0;
  logic [TotalW-1:0] want;

  always @(posedge clk) begin
    if (rst_n) begin
      in_acc   = in_ch.valid && in_ch.ready;
      out_acc  = out_ch.valid && out_ch.ready;
      out_seen = out_ch.valid;
      if (out_acc) begin
        if (expected_totals.size() == 0) begin
          report_mismatch($sformatf("unexpected total %0d", out_ch.total_seconds));
        end else begin
          want = expected_totals.pop_front();
          if (out_ch.total_seconds !== want) begin
            report_mismatch($sformatf("total_seconds %0d, expected %0d",
                                      out_ch.total_seconds, want));
          end
        end
      end
      if (in_acc) absorb_byte(in_ch.text_byte, in_ch.end_of_text);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("ERROR: timeout after %0d cycles", cycle_count);
      $display("FAIL text_duration_summer");
      $finish;
    end
  end

  // ---------------- drivers ----------------

  text_item_t  cur_item;
  int unsigned in_gap = 0;
  int unsigned in_count = 0;
  pace_e       in_pace = PaceRandom;

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_acc) begin
        in_count++;
        if (in_count % 50 == 0) in_pace = pace_e'($urandom_range(0, 2));
      end
      if (!in_ch.valid || in_acc) begin
        if (in_gap != 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (byte_feed.size() != 0) begin
          cur_item = byte_feed.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.text_byte   <= cur_item.value;
          in_ch.end_of_text <= cur_item.last;
          in_gap = draw_wait(in_pace);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  int unsigned out_stall = 0;

  // stall counts down only while a total is offered
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_acc) out_stall = draw_wait(pace_e'($urandom_range(0, 2)));
      else if (out_seen && out_stall != 0) out_stall--;
      out_ch.ready <= (out_stall == 0);
    end
  end

  // ---------------- sequence ----------------

  initial begin
    int unsigned random_goal;
    int unsigned drain;
    in_ch.valid       = 1'b0;
    in_ch.text_byte   = '0;
    in_ch.end_of_text = 1'b0;
    out_ch.ready      = 1'b0;
    out_stall         = draw_wait(PaceRandom);

    // NUL alone as the whole text
    queue_byte(ChNul, 1'b1);
    // largest fields, then one-digit fields padded with high bytes, last inside a word
    queue_str("99-99-99 1-2-3", 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_str("z", 1'b1);
    // leading sign fails; last on a period
    queue_str("-1-02-03", 1'b0);
    queue_byte(ChDot, 1'b1);
    queue_str("+9-5-7ab 5-45-0xy\t", 1'b1);

    random_goal = byte_feed.size() + RandomItems;
    while (byte_feed.size() < random_goal) gen_text();

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (byte_feed.size() != 0 || in_ch.valid) @(posedge clk);
    drain = 0;
    while (expected_totals.size() != 0 && drain < DrainLimit) begin
      @(posedge clk);
      drain++;
    end
    repeat (SettleCycles) @(posedge clk);
    if (expected_totals.size() != 0) begin
      report_mismatch($sformatf("%0d totals never arrived", expected_totals.size()));
    end

    if (error_count == 0) begin
      $display("PASS text_duration_summer");
    end else begin
      $display("FAIL text_duration_summer");
    end
    $finish;
  end

endmodule

FILE: text_duration_summer.f
src/tds_pkg.sv
src/tds_if.sv
src/tds_front.sv
src/tds_fifo.sv
src/tds_back.sv
src/text_duration_summer.sv
tb/sv/text_duration_summer_test.sv
